// ----- hw/rtl/u16u8_pkg.sv -----
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and byte-encoding functions for the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int CP_W   = 21;             // Unicode scalar value width
  localparam int LEN_W  = 2;              // byte count minus one
  localparam int QDEPTH = 2;              // entries in the front/back queue
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
  localparam logic [CP_W-1:0] LIM_1B    = 21'h00080;
  localparam logic [CP_W-1:0] LIM_2B    = 21'h00800;
  localparam logic [CP_W-1:0] LIM_3B    = 21'h10000;

  localparam logic [7:0] LEAD_2B = 8'hC0;
  localparam logic [7:0] LEAD_3B = 8'hE0;
  localparam logic [7:0] LEAD_4B = 8'hF0;
  localparam logic [7:0] CONT_B  = 8'h80;

  // Byte count codes (number of bytes minus one).
  localparam logic [LEN_W-1:0] LEN_ONE   = 2'd0;
  localparam logic [LEN_W-1:0] LEN_TWO   = 2'd1;
  localparam logic [LEN_W-1:0] LEN_THREE = 2'd2;
  localparam logic [LEN_W-1:0] LEN_FOUR  = 2'd3;

  // One decoded code point waiting to be serialized.
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
    logic             last;
  } q_entry_t;

  // Write side of the queue, driven by the front part.
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_wr_t;

  // Queue occupancy status.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Number of UTF-8 bytes minus one for a code point.
  function automatic logic [LEN_W-1:0] u16u8_len(input logic [CP_W-1:0] cp);
    logic [LEN_W-1:0] len;
    if (cp < LIM_1B) begin
      len = LEN_ONE;
    end else if (cp < LIM_2B) begin
      len = LEN_TWO;
    end else if (cp < LIM_3B) begin
      len = LEN_THREE;
    end else begin
      len = LEN_FOUR;
    end
    return len;
  endfunction

  // Byte number idx of the UTF-8 encoding of cp, whose length code is len.
  function automatic logic [7:0] u16u8_byte(input logic [CP_W-1:0]  cp,
                                            input logic [LEN_W-1:0] len,
                                            input logic [LEN_W-1:0] idx);
    logic [LEN_W-1:0] rem;
    logic [7:0]       b;
    rem = len - idx;
    if (idx == '0) begin
      unique case (len)
        LEN_ONE:   b = {1'b0, cp[6:0]};
        LEN_TWO:   b = LEAD_2B | {3'b000, cp[10:6]};
        LEN_THREE: b = LEAD_3B | {4'b0000, cp[15:12]};
        default:   b = LEAD_4B | {5'b00000, cp[20:18]};
      endcase
    end else begin
      unique case (rem)
        2'd0:    b = CONT_B | {2'b00, cp[5:0]};
        2'd1:    b = CONT_B | {2'b00, cp[11:6]};
        default: b = CONT_B | {2'b00, cp[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

// ----- hw/rtl/u16u8_front.sv -----
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and hands decoded code points to the
// queue.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [15:0]      in_code_unit,
  input  logic             in_final_unit,
  input  u16u8_pkg::q_stat_t q_stat,
  output u16u8_pkg::q_wr_t   q_wr
);
  import u16u8_pkg::*;

  logic       pend_valid_r, pend_valid_nxt;
  logic       pend_high_r,  pend_high_nxt;
  logic [9:0] pend_bits_r,  pend_bits_nxt;

  logic            accept;
  logic            is_sur;
  logic            is_low;
  logic            push;
  logic [CP_W-1:0] cp;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign is_sur   = (in_code_unit[15:11] == 5'b11011);
  assign is_low   = is_sur && in_code_unit[10];

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_high_nxt  = pend_high_r;
    pend_bits_nxt  = pend_bits_r;
    push           = 1'b0;
    cp             = '0;
    if (accept) begin
      if (pend_valid_r) begin
        // The follower is always consumed with the held surrogate.
        pend_valid_nxt = 1'b0;
        push           = 1'b1;
        if (pend_high_r && is_low) begin
          cp = {1'b0, pend_bits_r, in_code_unit[9:0]} + SUPP_BASE;
        end
      end else if (is_sur && !in_final_unit) begin
        pend_valid_nxt = 1'b1;
        pend_high_nxt  = !in_code_unit[10];
        pend_bits_nxt  = in_code_unit[9:0];
      end else if (is_sur) begin
        push = 1'b1;
      end else begin
        push = 1'b1;
        cp   = {5'b00000, in_code_unit};
      end
    end
  end

  assign q_wr.push       = push;
  assign q_wr.entry.cp   = cp;
  assign q_wr.entry.len  = u16u8_len(cp);
  assign q_wr.entry.last = in_final_unit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
    end
    pend_high_r <= pend_high_nxt;
    pend_bits_r <= pend_bits_nxt;
  end

endmodule

// ----- hw/rtl/u16u8_queue.sv -----
// ----------------------------------------------------------------------------
// u16u8_queue
// Short register queue of decoded code points between the front and back.
// ----------------------------------------------------------------------------
module u16u8_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  u16u8_pkg::q_wr_t    q_wr,
  input  logic                q_pop,
  output u16u8_pkg::q_entry_t q_head,
  output u16u8_pkg::q_stat_t  q_stat
);
  import u16u8_pkg::*;

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r,  count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    if (p == QPTR_W'(QDEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  always_comb begin
    wr_ptr_nxt = q_wr.push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (q_wr.push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_wr.push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign q_head       = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.entry;
    end
  end

endmodule

// ----- hw/rtl/u16u8_back.sv -----
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes the queue head into UTF-8 bytes, one byte per cycle while the
// output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                clk,
  input  logic                rst_n,
  input  u16u8_pkg::q_entry_t q_head,
  input  u16u8_pkg::q_stat_t  q_stat,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_run_last,
  output logic                out_string_end
);
  import u16u8_pkg::*;

  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_run_last_r, out_run_last_nxt;
  logic             out_string_end_r, out_string_end_nxt;

  logic advance;
  logic emit;
  logic at_last;

  assign advance = !out_valid_r || !out_stall;
  assign emit    = advance && !q_stat.empty;
  assign at_last = (idx_r == q_head.len);
  assign q_pop   = emit && at_last;

  always_comb begin
    idx_nxt            = idx_r;
    out_valid_nxt      = out_valid_r;
    out_byte_nxt       = out_byte_r;
    out_run_last_nxt   = out_run_last_r;
    out_string_end_nxt = out_string_end_r;
    if (emit) begin
      out_valid_nxt      = 1'b1;
      out_byte_nxt       = u16u8_byte(q_head.cp, q_head.len, idx_r);
      out_run_last_nxt   = at_last;
      out_string_end_nxt = at_last && q_head.last;
      idx_nxt            = at_last ? '0 : idx_r + 1'b1;
    end else if (advance) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_byte_r       <= out_byte_nxt;
    out_run_last_r   <= out_run_last_nxt;
    out_string_end_r <= out_string_end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_run_last   = out_run_last_r;
  assign out_string_end = out_string_end_r;

endmodule

// ----- hw/rtl/utf16_to_utf8_transcoder.sv -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Streams UTF-16 code units in, UTF-8 bytes out, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// Each accepted item is one UTF-16 code unit plus a flag marking the last unit
// of a string. The block emits one UTF-8 byte per cycle on the output channel
// while the output is not stalled and the queue is not empty: a unit
// outside the surrogate range yields 1, 2 or 3 bytes, a valid high/low
// surrogate pair yields 4 bytes on the second unit, and a held surrogate
// yields none. Any malformed surrogate sequence (a high surrogate not
// followed by a low one, a low surrogate that opens a pair, or a surrogate
// as the last unit of a string) yields a single 0x00 byte, and the follower
// of a held surrogate is always consumed with it. The sustained rate is set
// by the single-byte output port. Input items are accepted back to back
// while the two-entry code point queue has room, so the input side keeps
// working while the output is stalled. out_run_last marks the last byte of
// each item and out_string_end the last byte of an item that carried
// in_final_unit.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_code_unit,
  input  logic        in_final_unit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_string_end
);
  import u16u8_pkg::*;

  q_wr_t    q_wr;
  q_entry_t q_head;
  q_stat_t  q_stat;
  logic     q_pop;

  // The front part pairs surrogates and computes each code point and its
  // UTF-8 length as the item is accepted.
  u16u8_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_code_unit  (in_code_unit),
    .in_final_unit (in_final_unit),
    .q_stat        (q_stat),
    .q_wr          (q_wr)
  );

  // The queue decouples decoding from byte serialization.
  u16u8_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  // The back part walks the bytes of the head entry and pops it as the
  // last byte is loaded into the output register.
  u16u8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

  // The end of a string always closes the run of its item.
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_end |-> out_run_last)
    else $error("string end without run end");

  // The front never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_stat.full)
    else $error("queue overflow");

  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue underflow");

endmodule
